/* design/lrgd_pkg.sv */
// ----------------------------------------------------------------------------
// lrgd_pkg: shared types and constants for the gradient descent trainer
// Register indexes, reset values and widths used across the block.
// ----------------------------------------------------------------------------
package lrgd_pkg;
	localparam int unsigned MAX_POINTS_DEF = 1024;
	localparam int unsigned ITER_W = 20;
	localparam int unsigned LR_W = 16;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned USED_W = 11;
	localparam logic [ITER_W-1:0] ITER_RESET = 20'd20000;
	localparam logic [LR_W-1:0] LR_RESET = 16'd66;
	localparam logic [CFG_IDX_W-1:0] REG_ITER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LR = 8'd1;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               last;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] weight;
		logic signed [31:0] bias;
		logic [USED_W-1:0]  points_used;
		logic               points_dropped;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

/* design/lrgd_if.sv */
// ----------------------------------------------------------------------------
// lrgd_if: valid/ready channel
// Generic beat channel carrying a payload of type T.
// ----------------------------------------------------------------------------
interface lrgd_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/lrgd_div.sv */
// ----------------------------------------------------------------------------
// lrgd_div: sequential signed divider
// Restoring divide, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lrgd_div #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic                 done,
	output logic signed [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [NW:0]   r_q;
	logic [DW-1:0] d_q;
	logic          neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   r_sh;
	logic [NW:0]   r_sub;

	assign r_sh  = {r_q[NW-1:0], q_q[NW-1]};
	assign r_sub = r_sh - {{(NW+1-DW){1'b0}}, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				neg_q  <= num[NW-1];
				q_q    <= num[NW-1] ? -num : num;
				r_q    <= '0;
				d_q    <= den;
			end else if (busy_q) begin
				if (!r_sub[NW]) begin
					r_q <= r_sub;
					q_q <= {q_q[NW-2:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

/* design/lrgd_core.sv */
// ----------------------------------------------------------------------------
// lrgd_core: sample memories and training sequencer
// Stores points, then sweeps the memories once per iteration.
// ----------------------------------------------------------------------------
module lrgd_core #(
	parameter int unsigned MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lrgd_pkg::ITER_W-1:0]       iter_cfg,
	input  logic [lrgd_pkg::LR_W-1:0]         lr_cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lrgd_pkg::sample_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lrgd_pkg::result_t                 out_data
);
	import lrgd_pkg::*;
	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned NW = $clog2(MAX_POINTS + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_ITER, S_RD, S_MUL1, S_ERR, S_MUL2, S_ACC, S_DIVW, S_DIVB,
		S_STEP, S_UPD, S_OUT
	} state_t;

	logic [31:0] x_mem [MAX_POINTS];
	logic [31:0] y_mem [MAX_POINTS];
	logic [31:0] x_rd, y_rd;
	logic [AW-1:0] rd_addr;

	state_t state_q;
	logic [NW-1:0] count_q, idx_q;
	logic over_q;
	logic [ITER_W-1:0] it_q;
	logic signed [31:0] w_q, b_q, e_q, gw_q, gb_q;
	logic signed [63:0] wx_q, ex_q;
	logic signed [63:0] exs_q;
	logic signed [47:0] es_q;
	logic signed [63:0] sw_q, sb_q;
	logic div_start, div_done;
	logic signed [63:0] div_num, div_quo;
	logic accept;

	assign in_ready = (state_q == S_LOAD);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept && count_q < NW'(MAX_POINTS)) begin
			x_mem[count_q[AW-1:0]] <= in_data.x;
			y_mem[count_q[AW-1:0]] <= in_data.y;
		end
		x_rd <= x_mem[rd_addr];
		y_rd <= y_mem[rd_addr];
	end
	assign rd_addr = idx_q[AW-1:0];

	lrgd_div #(.NW(64), .DW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(count_q), .done(div_done), .quo(div_quo)
	);

	logic signed [63:0] p_full, ex_full;
	assign p_full = (wx_q >>> 16) + 64'(b_q) - 64'($signed(y_rd));
	assign ex_full = ex_q >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			count_q   <= '0;
			over_q    <= 1'b0;
			out_valid <= 1'b0;
			div_start <= 1'b0;
		end else begin
			div_start <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (count_q < NW'(MAX_POINTS)) count_q <= count_q + 1'b1;
						else over_q <= 1'b1;
						if (in_data.last) begin
							w_q <= '0; b_q <= '0; it_q <= '0;
							state_q <= S_ITER;
						end
					end
				end
				S_ITER: begin
					if (it_q == iter_cfg) state_q <= S_OUT;
					else begin
						exs_q <= '0; es_q <= '0; idx_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_MUL1;
				S_MUL1: begin
					wx_q <= 64'(w_q) * 64'($signed(x_rd));
					state_q <= S_ERR;
				end
				S_ERR: begin
					e_q <= sat32(66'(p_full));
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					ex_q <= 64'(e_q) * 64'($signed(x_rd));
					state_q <= S_ACC;
				end
				S_ACC: begin
					exs_q <= exs_q + ex_full;
					es_q  <= es_q + 48'(e_q);
					idx_q <= idx_q + 1'b1;
					if (idx_q + 1'b1 == count_q) begin
						div_start <= 1'b1;
						div_num   <= exs_q + ex_full;
						state_q   <= S_DIVW;
					end else state_q <= S_RD;
				end
				S_DIVW: if (div_done) begin
					gw_q <= sat32(66'(div_quo) <<< 1);
					div_start <= 1'b1;
					div_num   <= 64'(es_q);
					state_q   <= S_DIVB;
				end
				S_DIVB: if (div_done) begin
					gb_q <= sat32(66'(div_quo) <<< 1);
					state_q <= S_STEP;
				end
				S_STEP: begin
					sw_q <= 64'(gw_q) * $signed({48'd0, lr_cfg});
					sb_q <= 64'(gb_q) * $signed({48'd0, lr_cfg});
					state_q <= S_UPD;
				end
				S_UPD: begin
					w_q <= sat32(66'(w_q) - 66'(sw_q >>> 16));
					b_q <= sat32(66'(b_q) - 66'(sb_q >>> 16));
					it_q <= it_q + 1'b1;
					state_q <= S_ITER;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						out_data.weight <= w_q;
						out_data.bias <= b_q;
						out_data.points_used <= USED_W'(count_q);
						out_data.points_dropped <= over_q;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						count_q <= '0;
						over_q <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

/* design/linear_regression_gradient_descent_top.sv */
// Loading: points load one per cycle; a last point starts training, which
//   sweeps the stored points once per iteration through one shared read
//   address and runs the bit-serial divider once per gradient.
// Throughput: one point per cycle while loading; one run at a time.
// Reset: arst_n clears count, flags and registers to 20000 iterations, rate 66.
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent_top: fixed-point linear regression trainer
// Sample beats in, one weight/bias beat out per data set; config write port.
// ----------------------------------------------------------------------------
module linear_regression_gradient_descent_top #(
	parameter int unsigned MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	lrgd_if.sink   samples,
	lrgd_if.source results,
	lrgd_if.sink   cfg
);
	import lrgd_pkg::*;
	logic [ITER_W-1:0] iter_q;
	logic [LR_W-1:0]   lr_q;
	cfg_t cfg_beat;

	// config is always accepted; out-of-range indexes are ignored
	assign cfg.ready = 1'b1;
	assign cfg_beat = cfg.data;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= ITER_RESET;
			lr_q   <= LR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_beat.index)
				REG_ITER: iter_q <= cfg_beat.data[ITER_W-1:0];
				REG_LR:   lr_q   <= cfg_beat.data[LR_W-1:0];
				default:  ;
			endcase
		end
	end

	lrgd_core #(.MAX_POINTS(MAX_POINTS)) u_core (
		.clk(clk), .arst_n(arst_n), .iter_cfg(iter_q), .lr_cfg(lr_q),
		.in_valid(samples.valid), .in_ready(samples.ready), .in_data(samples.data),
		.out_valid(results.valid), .out_ready(results.ready), .out_data(results.data)
	);
endmodule
